@@ hdl/lmts_pkg.sv @@
`default_nettype none

package lmts_pkg;

    localparam int TIME_BITS_DEF = 20;
    localparam int CFG_ADDR_W    = 3;
    localparam int CFG_DATA_W    = 12;
    localparam int OUT_TIME_W    = 20;
    localparam logic [OUT_TIME_W-1:0] OUT_TIME_MAX = {OUT_TIME_W{1'b1}};

    // configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_STEP_PERIOD = 3'd0,
        REG_FULL_SPEED  = 3'd1,
        REG_SPEED_INC   = 3'd2,
        REG_NUDGE_SPEED = 3'd3,
        REG_NUDGE_MS    = 3'd4
    } cfg_index_t;

    localparam logic [9:0]  STEP_PERIOD_RST = 10'd50;
    localparam logic [7:0]  FULL_SPEED_RST  = 8'd200;
    localparam logic [7:0]  SPEED_INC_RST   = 8'd10;
    localparam logic [7:0]  NUDGE_SPEED_RST = 8'd100;
    localparam logic [11:0] NUDGE_MS_RST    = 12'd600;

    // request kinds
    localparam logic [1:0] REQ_TICK      = 2'd0;
    localparam logic [1:0] REQ_CALIBRATE = 2'd1;
    localparam logic [1:0] REQ_TURN      = 2'd2;

    // drive modes
    localparam logic [1:0] DRIVE_RELEASE = 2'd0;
    localparam logic [1:0] DRIVE_RIGHT   = 2'd1;
    localparam logic [1:0] DRIVE_LEFT    = 2'd2;

    typedef struct packed {
        logic [9:0]  step_period_ms;
        logic [7:0]  full_speed;
        logic [7:0]  speed_increment;
        logic [7:0]  nudge_speed;
        logic [11:0] nudge_ms;
    } config_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic       move_dir;
        logic       limit_left;
        logic       limit_right;
        logic       stall_seen;
    } request_t;

    typedef struct packed {
        logic [1:0]            drive_mode;
        logic [7:0]            drive_speed;
        logic                  busy_res;
        logic                  finished;
        logic                  error_code;
        logic                  turned_flag;
        logic [OUT_TIME_W-1:0] centre_time_ms;
    } result_t;

endpackage

`default_nettype wire

@@ hdl/lmts_cfg.sv @@
`default_nettype none

module lmts_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [lmts_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [lmts_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output lmts_pkg::config_t                     cfg
);

    lmts_pkg::config_t cfg_reg;
    lmts_pkg::config_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                lmts_pkg::REG_STEP_PERIOD: cfg_next.step_period_ms  = cfg_wdata[9:0];
                lmts_pkg::REG_FULL_SPEED:  cfg_next.full_speed      = cfg_wdata[7:0];
                lmts_pkg::REG_SPEED_INC:   cfg_next.speed_increment = cfg_wdata[7:0];
                lmts_pkg::REG_NUDGE_SPEED: cfg_next.nudge_speed     = cfg_wdata[7:0];
                lmts_pkg::REG_NUDGE_MS:    cfg_next.nudge_ms        = cfg_wdata[11:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_period_ms  <= lmts_pkg::STEP_PERIOD_RST;
            cfg_reg.full_speed      <= lmts_pkg::FULL_SPEED_RST;
            cfg_reg.speed_increment <= lmts_pkg::SPEED_INC_RST;
            cfg_reg.nudge_speed     <= lmts_pkg::NUDGE_SPEED_RST;
            cfg_reg.nudge_ms        <= lmts_pkg::NUDGE_MS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ hdl/lmts_core.sv @@
`default_nettype none

module lmts_core #(
    parameter int TIME_BITS = lmts_pkg::TIME_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step_en,
    input  wire lmts_pkg::request_t  req,
    input  wire lmts_pkg::config_t   cfg,
    output lmts_pkg::result_t        res
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_RAMP,
        PH_FULL,
        PH_NUDGE,
        PH_CENTRE
    } phase_t;

    typedef struct packed {
        phase_t                 phase;
        logic                   dir;
        logic [7:0]             speed;
        logic [11:0]            step;
        logic [TIME_BITS-1:0]   trav;
        logic [TIME_BITS-1:0]   centre;
        logic                   cal;
        logic                   did_turn;
        logic                   leg;
        logic                   err;
        logic                   pulse;
    } seq_t;

    seq_t st_reg;
    seq_t st_next;

    function automatic seq_t do_finish(seq_t s, logic err);
        seq_t r;
        r       = s;
        r.phase = PH_IDLE;
        r.speed = '0;
        r.err   = err;
        r.cal   = 1'b0;
        r.leg   = 1'b0;
        r.pulse = 1'b1;
        return r;
    endfunction

    function automatic seq_t do_start_centre(seq_t s);
        seq_t r;
        r       = s;
        r.dir   = ~r.dir;
        r.trav  = r.centre;
        r.speed = '0;
        r.step  = '0;
        if (r.centre == '0)
            r = do_finish(r, 1'b0);
        else
            r.phase = PH_CENTRE;
        return r;
    endfunction

    function automatic seq_t do_end_cal(seq_t s);
        seq_t r;
        r        = s;
        r.centre = r.trav >> 1;
        return do_start_centre(r);
    endfunction

    function automatic seq_t do_leg_done(seq_t s, logic moved, logic ll, logic lr);
        seq_t r;
        r = s;
        if (r.cal)
        begin
            if (!r.leg)
            begin
                // first calibration leg done, start the timed traverse back
                r.leg  = 1'b1;
                r.trav = '0;
                r.dir  = ~r.dir;
                if (r.dir ? ll : lr)
                    r = do_end_cal(r);
                else
                begin
                    r.phase = PH_RAMP;
                    r.speed = '0;
                    r.step  = '0;
                end
            end
            else
                r = do_end_cal(r);
        end
        else if (moved)
            r = do_start_centre(r);
        else
            r = do_finish(r, 1'b0);
        return r;
    endfunction

    logic [11:0] step_inc;
    logic        step_hit;
    logic [8:0]  speed_sum;
    logic        lim;

    assign step_inc  = st_reg.step + 12'd1;
    assign step_hit  = step_inc >= {2'b00, cfg.step_period_ms};
    assign speed_sum = {1'b0, st_reg.speed} + {1'b0, cfg.speed_increment};
    assign lim       = st_reg.dir ? req.limit_left : req.limit_right;

    always_comb
    begin
        st_next       = st_reg;
        st_next.pulse = 1'b0;
        if (st_reg.phase == PH_IDLE && req.req_type == lmts_pkg::REQ_CALIBRATE)
        begin
            st_next.cal = 1'b1;
            st_next.leg = 1'b0;
            st_next.err = 1'b0;
            st_next.dir = ~req.limit_left;
            if (st_next.dir ? req.limit_left : req.limit_right)
                st_next = do_leg_done(st_next, 1'b0, req.limit_left, req.limit_right);
            else
            begin
                st_next.phase = PH_RAMP;
                st_next.speed = '0;
                st_next.step  = '0;
            end
        end
        else if (st_reg.phase == PH_IDLE && req.req_type == lmts_pkg::REQ_TURN)
        begin
            st_next.cal      = 1'b0;
            st_next.leg      = 1'b0;
            st_next.err      = 1'b0;
            st_next.dir      = req.move_dir;
            st_next.did_turn = !(req.move_dir ? req.limit_left : req.limit_right);
            if (!st_next.did_turn)
                st_next = do_finish(st_next, 1'b0);
            else
            begin
                st_next.phase = PH_RAMP;
                st_next.speed = '0;
                st_next.step  = '0;
            end
        end
        else if (req.req_type == lmts_pkg::REQ_TICK && st_reg.phase != PH_IDLE)
        begin
            // traverse time counts on the second calibration leg, saturating
            if (st_reg.phase != PH_CENTRE && st_reg.cal && st_reg.leg && st_reg.trav != '1)
                st_next.trav = st_reg.trav + 1'b1;
            case (st_reg.phase)
                PH_RAMP, PH_FULL:
                begin
                    st_next.step = step_hit ? 12'd0 : step_inc;
                    if (step_hit)
                    begin
                        if (req.stall_seen)
                            st_next = do_finish(st_next, 1'b1);
                        else if (lim)
                        begin
                            st_next.phase = PH_NUDGE;
                            st_next.speed = cfg.nudge_speed;
                            st_next.step  = '0;
                            if (cfg.nudge_ms == '0)
                                st_next = do_leg_done(st_next, 1'b1, req.limit_left,
                                                      req.limit_right);
                        end
                        else if (st_reg.phase == PH_RAMP)
                        begin
                            if (speed_sum > {1'b0, cfg.full_speed})
                            begin
                                st_next.phase = PH_FULL;
                                st_next.speed = cfg.full_speed;
                            end
                            else
                                st_next.speed = speed_sum[7:0];
                        end
                    end
                end
                PH_NUDGE:
                begin
                    st_next.step = step_inc;
                    if (step_inc >= cfg.nudge_ms)
                        st_next = do_leg_done(st_next, 1'b1, req.limit_left, req.limit_right);
                end
                PH_CENTRE:
                begin
                    st_next.trav = st_reg.trav - 1'b1;
                    if (st_next.trav == '0)
                        st_next = do_finish(st_next, 1'b0);
                    else
                    begin
                        st_next.step = step_hit ? 12'd0 : step_inc;
                        if (step_hit && speed_sum <= {1'b0, cfg.full_speed})
                            st_next.speed = speed_sum[7:0];
                    end
                end
                default:
                    st_next.phase = PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.phase    <= PH_IDLE;
            st_reg.dir      <= 1'b0;
            st_reg.speed    <= '0;
            st_reg.step     <= '0;
            st_reg.trav     <= '0;
            st_reg.centre   <= '0;
            st_reg.cal      <= 1'b0;
            st_reg.did_turn <= 1'b0;
            st_reg.leg      <= 1'b0;
            st_reg.err      <= 1'b0;
            st_reg.pulse    <= 1'b0;
        end
        else if (step_en)
        begin
            st_reg <= st_next;
        end
    end

    logic [32:0] centre_ext;
    logic        active;

    assign centre_ext = 33'(st_next.centre);
    assign active     = st_next.phase != PH_IDLE;

    always_comb
    begin
        res.drive_mode  = !active ? lmts_pkg::DRIVE_RELEASE :
                          (st_next.dir ? lmts_pkg::DRIVE_LEFT : lmts_pkg::DRIVE_RIGHT);
        res.drive_speed = active ? st_next.speed : 8'd0;
        res.busy_res    = active;
        res.finished    = st_next.pulse;
        res.error_code  = st_next.err;
        res.turned_flag = st_next.did_turn;
        res.centre_time_ms = (centre_ext > 33'(lmts_pkg::OUT_TIME_MAX)) ?
                             lmts_pkg::OUT_TIME_MAX : centre_ext[lmts_pkg::OUT_TIME_W-1:0];
    end

endmodule

`default_nettype wire

@@ hdl/lock_motor_turn_sequencer_top.sv @@
// Lock motor turn sequencer. Each request on the slave stream is a one-millisecond
// tick carrying the limit switches and the stall flag, or a calibrate or turn
// command; every request yields exactly one status word on the master stream
// (drive mode and speed, busy, a finished pulse, the error of the last sequence,
// whether the last turn moved, and the calibrated centre time). Commands that
// arrive while a sequence runs only report status. One request is taken every
// clock cycle unless the full result register is stalled; it passes one input
// register, then one sequencer pass into the result register. Configuration
// writes take effect on the next cycle and belong to idle periods.
`default_nettype none

module lock_motor_turn_sequencer_top #(
    parameter int TIME_BITS = lmts_pkg::TIME_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // move_dir, limit_left, limit_right, stall_seen, zero fill
    input  wire logic [7:0]                       s_tdata,
    // req_type
    input  wire logic [1:0]                       s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // drive_mode, drive_speed, busy_res, finished, error_code, turned_flag,
    // centre_time_ms, zero fill
    output logic [39:0]                           m_tdata,
    input  wire logic                             cfg_we,
    input  wire logic [lmts_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [lmts_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    lmts_pkg::config_t  cfg;
    lmts_pkg::request_t in_req_reg;
    lmts_pkg::request_t in_req_next;
    logic               in_valid_reg;
    logic               in_valid_next;
    lmts_pkg::result_t  out_res_reg;
    lmts_pkg::result_t  out_res_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    lmts_pkg::result_t  core_res;
    logic               advance;
    logic               s_take;

    lmts_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    lmts_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .req     (in_req_reg),
        .cfg     (cfg),
        .res     (core_res)
    );

    // request moves on when the result register is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    always_comb
    begin
        in_req_next   = in_req_reg;
        in_valid_next = in_valid_reg;
        if (s_take)
        begin
            in_req_next.req_type    = s_tuser;
            in_req_next.move_dir    = s_tdata[0];
            in_req_next.limit_left  = s_tdata[1];
            in_req_next.limit_right = s_tdata[2];
            in_req_next.stall_seen  = s_tdata[3];
            in_valid_next           = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_res_next   = out_res_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_res_next   = core_res;
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_req_reg  <= in_req_next;
        out_res_reg <= out_res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0,
                       out_res_reg.centre_time_ms,
                       out_res_reg.turned_flag,
                       out_res_reg.error_code,
                       out_res_reg.finished,
                       out_res_reg.busy_res,
                       out_res_reg.drive_speed,
                       out_res_reg.drive_mode};

    a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.finished |-> !out_res_reg.busy_res)
        else $error("finished pulse while still busy");

    a_idle_released: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_res_reg.busy_res |->
            out_res_reg.drive_mode == lmts_pkg::DRIVE_RELEASE && out_res_reg.drive_speed == 8'd0)
        else $error("motor driven while idle");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with empty result register");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed request produced no result");

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 4000;
    localparam logic [19:0] TRAVERSE_MAX = 20'hFFFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RAMP,
        ST_FULL,
        ST_NUDGE,
        ST_CENTRE
    } seq_phase_t;

    typedef struct {
        seq_phase_t  phase;
        logic        dir;
        logic [7:0]  speed;
        logic [11:0] step_tmr;
        logic [19:0] trav;
        logic [19:0] centre;
        logic        cal;
        logic        cal_leg;
        logic        did_turn;
        logic        err;
        logic        pulse;
    } motor_state_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [lmts_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [lmts_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    lock_motor_turn_sequencer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    lmts_pkg::config_t cfg = '{lmts_pkg::STEP_PERIOD_RST, lmts_pkg::FULL_SPEED_RST,
                               lmts_pkg::SPEED_INC_RST, lmts_pkg::NUDGE_SPEED_RST,
                               lmts_pkg::NUDGE_MS_RST};
    motor_state_t gen_st;
    motor_state_t model_st;

    lmts_pkg::request_t pending_reqs[$];
    logic [39:0]        expected_status[$];
    lmts_pkg::request_t next_req;
    lmts_pkg::request_t taken_req;
    logic [39:0]        want;

    int queued = 0;
    int accepted = 0;
    int checked = 0;
    int errors_seen = 0;
    int quiet = 0;
    int hold_left = 0;
    logic hold_done = 1'b0;
    logic in_taken = 1'b0;
    int leg_ticks = 0;
    int leg_target = 0;

    // ---------------- sequencer prediction ----------------

    function automatic void seq_finish(inout motor_state_t st, input logic e);
        st.phase   = ST_IDLE;
        st.speed   = '0;
        st.err     = e;
        st.cal     = 1'b0;
        st.cal_leg = 1'b0;
        st.pulse   = 1'b1;
    endfunction

    function automatic void seq_centre(inout motor_state_t st);
        st.dir      = ~st.dir;
        st.trav     = st.centre;
        st.speed    = '0;
        st.step_tmr = '0;
        if (st.trav == '0)
            seq_finish(st, 1'b0);
        else
            st.phase = ST_CENTRE;
    endfunction

    // returns 0 when already sitting on the limit in that direction
    function automatic logic seq_leg(inout motor_state_t st, input logic d,
                                     input logic ll, input logic lr);
        st.dir = d;
        if (d ? ll : lr)
            return 1'b0;
        st.phase    = ST_RAMP;
        st.speed    = '0;
        st.step_tmr = '0;
        return 1'b1;
    endfunction

    function automatic void seq_end_cal(inout motor_state_t st);
        st.centre = st.trav >> 1;
        seq_centre(st);
    endfunction

    function automatic void seq_leg_done(inout motor_state_t st, input logic moved,
                                         input logic ll, input logic lr);
        if (st.cal)
        begin
            if (!st.cal_leg)
            begin
                st.cal_leg = 1'b1;
                st.trav    = '0;
                if (!seq_leg(st, ~st.dir, ll, lr))
                    seq_end_cal(st);
            end
            else
                seq_end_cal(st);
        end
        else if (moved)
            seq_centre(st);
        else
            seq_finish(st, 1'b0);
    endfunction

    function automatic logic seq_step_due(inout motor_state_t st, input logic [9:0] period);
        st.step_tmr = st.step_tmr + 12'd1;
        if (st.step_tmr >= {2'b00, period})
        begin
            st.step_tmr = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [39:0] seq_apply(inout motor_state_t st,
                                              input lmts_pkg::config_t c,
                                              input lmts_pkg::request_t rq);
        logic [8:0] nxt;
        logic       lim;
        logic [1:0] mode;
        logic [7:0] spd;
        st.pulse = 1'b0;
        if (st.phase == ST_IDLE && rq.req_type == lmts_pkg::REQ_CALIBRATE)
        begin
            st.cal     = 1'b1;
            st.cal_leg = 1'b0;
            st.err     = 1'b0;
            if (!seq_leg(st, ~rq.limit_left, rq.limit_left, rq.limit_right))
                seq_leg_done(st, 1'b0, rq.limit_left, rq.limit_right);
        end
        else if (st.phase == ST_IDLE && rq.req_type == lmts_pkg::REQ_TURN)
        begin
            st.cal      = 1'b0;
            st.cal_leg  = 1'b0;
            st.err      = 1'b0;
            st.did_turn = seq_leg(st, rq.move_dir, rq.limit_left, rq.limit_right);
            if (!st.did_turn)
                seq_finish(st, 1'b0);
        end
        else if (rq.req_type == lmts_pkg::REQ_TICK && st.phase != ST_IDLE)
        begin
            // traverse only counts on the second calibration leg
            if (st.phase != ST_CENTRE && st.cal && st.cal_leg && st.trav != TRAVERSE_MAX)
                st.trav = st.trav + 20'd1;
            lim = st.dir ? rq.limit_left : rq.limit_right;
            case (st.phase)
                ST_RAMP, ST_FULL:
                begin
                    if (seq_step_due(st, c.step_period_ms))
                    begin
                        if (rq.stall_seen)
                            seq_finish(st, 1'b1);
                        else if (lim)
                        begin
                            st.phase    = ST_NUDGE;
                            st.speed    = c.nudge_speed;
                            st.step_tmr = '0;
                            if (c.nudge_ms == '0)
                                seq_leg_done(st, 1'b1, rq.limit_left, rq.limit_right);
                        end
                        else if (st.phase == ST_RAMP)
                        begin
                            nxt = {1'b0, st.speed} + {1'b0, c.speed_increment};
                            if (nxt > {1'b0, c.full_speed})
                            begin
                                st.phase = ST_FULL;
                                st.speed = c.full_speed;
                            end
                            else
                                st.speed = nxt[7:0];
                        end
                    end
                end
                ST_NUDGE:
                begin
                    st.step_tmr = st.step_tmr + 12'd1;
                    if (st.step_tmr >= c.nudge_ms)
                        seq_leg_done(st, 1'b1, rq.limit_left, rq.limit_right);
                end
                ST_CENTRE:
                begin
                    st.trav = st.trav - 20'd1;
                    if (st.trav == '0)
                        seq_finish(st, 1'b0);
                    else if (seq_step_due(st, c.step_period_ms))
                    begin
                        nxt = {1'b0, st.speed} + {1'b0, c.speed_increment};
                        if (nxt <= {1'b0, c.full_speed})
                            st.speed = nxt[7:0];
                    end
                end
                default:
                    st.phase = ST_IDLE;
            endcase
        end
        if (st.phase == ST_IDLE)
        begin
            mode = lmts_pkg::DRIVE_RELEASE;
            spd  = '0;
        end
        else
        begin
            mode = st.dir ? lmts_pkg::DRIVE_LEFT : lmts_pkg::DRIVE_RIGHT;
            spd  = st.speed;
        end
        return {6'b0, st.centre, st.did_turn, st.err, st.pulse,
                (st.phase != ST_IDLE), spd, mode};
    endfunction

    // ---------------- stimulus generation ----------------

    task automatic queue_req(input logic [1:0] rt, input logic d, input logic ll,
                             input logic lr, input logic sl);
        lmts_pkg::request_t rq;
        logic [39:0]        unused_status;
        logic               was_leg;
        logic               was_dir;
        rq.req_type    = rt;
        rq.move_dir    = d;
        rq.limit_left  = ll;
        rq.limit_right = lr;
        rq.stall_seen  = sl;
        was_leg = (gen_st.phase == ST_RAMP || gen_st.phase == ST_FULL);
        was_dir = gen_st.dir;
        unused_status = seq_apply(gen_st, cfg, rq);
        pending_reqs.push_back(rq);
        queued++;
        // pick when the limit switch trips for each new leg
        if ((gen_st.phase == ST_RAMP || gen_st.phase == ST_FULL)
            && (!was_leg || gen_st.dir != was_dir))
        begin
            leg_ticks  = 0;
            leg_target = int'($urandom_range(0, 40));
        end
        else
            leg_ticks++;
    endtask

    task automatic queue_random_item();
        int         r;
        logic       toward;
        logic       opp;
        logic       sl;
        logic [1:0] rt;
        r = int'($urandom_range(0, 99));
        if (gen_st.phase == ST_IDLE)
        begin
            if (r < 8)
                queue_req(lmts_pkg::REQ_TICK, 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            else if (r < 11)
                queue_req(REQ_UNUSED, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            else
            begin
                rt = $urandom_range(0, 1) ? lmts_pkg::REQ_TURN : lmts_pkg::REQ_CALIBRATE;
                queue_req(rt, 1'($urandom_range(0, 1)), $urandom_range(0, 99) < 15,
                          $urandom_range(0, 99) < 15, 1'($urandom_range(0, 1)));
            end
        end
        else if (r < 5)
        begin
            // command while busy, must be ignored
            case ($urandom_range(0, 2))
                0: rt = lmts_pkg::REQ_CALIBRATE;
                1: rt = lmts_pkg::REQ_TURN;
                default: rt = REQ_UNUSED;
            endcase
            queue_req(rt, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
        else
        begin
            opp = $urandom_range(0, 99) < 20;
            case (gen_st.phase)
                ST_RAMP, ST_FULL:
                begin
                    toward = (leg_ticks >= leg_target);
                    sl     = ($urandom_range(0, 39) == 0);
                end
                ST_NUDGE:
                begin
                    toward = ($urandom_range(0, 9) != 0);
                    sl     = 1'($urandom_range(0, 1));
                end
                default:
                begin
                    toward = ($urandom_range(0, 2) == 0);
                    sl     = 1'($urandom_range(0, 1));
                end
            endcase
            queue_req(lmts_pkg::REQ_TICK, 1'($urandom_range(0, 1)),
                      gen_st.dir ? toward : opp, gen_st.dir ? opp : toward, sl);
        end
    endtask

    task automatic queue_until_idle();
        while (gen_st.phase != ST_IDLE)
            queue_req(lmts_pkg::REQ_TICK, 1'b0, gen_st.dir, ~gen_st.dir, 1'b0);
    endtask

    task automatic wait_idle();
        while (accepted != queued || checked != accepted)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input lmts_pkg::cfg_index_t idx,
                             input logic [lmts_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic apply_settings(input logic [9:0] sp, input logic [7:0] fs,
                                  input logic [7:0] si, input logic [7:0] ns,
                                  input logic [11:0] nm);
        write_reg(lmts_pkg::REG_STEP_PERIOD, {2'b00, sp});
        write_reg(lmts_pkg::REG_FULL_SPEED, {4'b0, fs});
        write_reg(lmts_pkg::REG_SPEED_INC, {4'b0, si});
        write_reg(lmts_pkg::REG_NUDGE_SPEED, {4'b0, ns});
        write_reg(lmts_pkg::REG_NUDGE_MS, nm);
        cfg = '{sp, fs, si, ns, nm};
        repeat (2) @(negedge clk);
    endtask

    task automatic run_phase(input int n);
        repeat (n) queue_random_item();
        queue_until_idle();
        wait_idle();
    endtask

    // ---------------- request driver ----------------

    // gaps only outside the quiet window
    function automatic logic take_gap();
        return !(accepted >= 450 && accepted < 650) && ($urandom_range(0, 99) < 15);
    endfunction

    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || in_taken))
        begin
            if (pending_reqs.size() != 0 && !take_gap())
            begin
                next_req = pending_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {4'b0, next_req.stall_seen, next_req.limit_right,
                             next_req.limit_left, next_req.move_dir};
                s_tuser  <= next_req.req_type;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // status receiver, with one long hold-off to back up the pipeline
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (!hold_done && checked >= 250)
        begin
            hold_done <= 1'b1;
            hold_left <= 300;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= !take_gap();
    end

    // ---------------- status checking ----------------

    task automatic check_field(input string fname, input int unsigned exp_v,
                               input int unsigned got_v);
        if (exp_v != got_v)
        begin
            $error("%s: expected %0d, got %0d", fname, exp_v, got_v);
            errors_seen++;
        end
    endtask

    always @(posedge clk)
    begin
        in_taken <= rst_n && s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            taken_req.req_type    = s_tuser;
            taken_req.move_dir    = s_tdata[0];
            taken_req.limit_left  = s_tdata[1];
            taken_req.limit_right = s_tdata[2];
            taken_req.stall_seen  = s_tdata[3];
            expected_status.push_back(seq_apply(model_st, cfg, taken_req));
            accepted++;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_status.size() == 0)
            begin
                $error("status word with no request outstanding: %h", m_tdata);
                errors_seen++;
            end
            else
            begin
                want = expected_status.pop_front();
                check_field("drive_mode", 32'(want[1:0]), 32'(m_tdata[1:0]));
                check_field("drive_speed", 32'(want[9:2]), 32'(m_tdata[9:2]));
                check_field("busy_res", 32'(want[10]), 32'(m_tdata[10]));
                check_field("finished", 32'(want[11]), 32'(m_tdata[11]));
                check_field("error_code", 32'(want[12]), 32'(m_tdata[12]));
                check_field("turned_flag", 32'(want[13]), 32'(m_tdata[13]));
                check_field("centre_time_ms", 32'(want[33:14]), 32'(m_tdata[33:14]));
            end
            checked++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------- test sequence ----------------

    initial
    begin
        gen_st   = '{ST_IDLE, 1'b0, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
        model_st = gen_st;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // idle-level cases under the reset settings
        queue_req(lmts_pkg::REQ_TICK, 1'b1, 1'b1, 1'b1, 1'b1);
        queue_req(REQ_UNUSED, 1'b1, 1'b1, 1'b1, 1'b1);
        queue_req(lmts_pkg::REQ_TURN, 1'b0, 1'b0, 1'b1, 1'b0);   // already on right limit
        queue_req(lmts_pkg::REQ_TURN, 1'b1, 1'b1, 1'b0, 1'b0);   // already on left limit
        queue_req(lmts_pkg::REQ_CALIBRATE, 1'b0, 1'b1, 1'b1, 1'b0);
        wait_idle();

        apply_settings(10'd1, 8'd255, 8'd255, 8'd255, 12'd0);
        queue_req(lmts_pkg::REQ_TURN, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_req(lmts_pkg::REQ_TURN, 1'b1, 1'b0, 1'b0, 1'b0);   // ignored while busy
        queue_req(lmts_pkg::REQ_TICK, 1'b0, 1'b0, 1'b0, 1'b1);   // stall abort
        queue_req(lmts_pkg::REQ_CALIBRATE, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_req(lmts_pkg::REQ_TICK, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_req(lmts_pkg::REQ_TICK, 1'b0, 1'b1, 1'b0, 1'b0);
        queue_req(lmts_pkg::REQ_TICK, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_req(lmts_pkg::REQ_TICK, 1'b1, 1'b0, 1'b0, 1'b0);
        queue_req(lmts_pkg::REQ_TICK, 1'b0, 1'b0, 1'b1, 1'b0);
        queue_req(lmts_pkg::REQ_TICK, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_req(lmts_pkg::REQ_TURN, 1'b0, 1'b1, 1'b0, 1'b0);
        queue_req(lmts_pkg::REQ_TICK, 1'b0, 1'b0, 1'b1, 1'b1);   // stall wins over limit
        queue_req(lmts_pkg::REQ_TURN, 1'b1, 1'b0, 1'b0, 1'b0);
        queue_req(lmts_pkg::REQ_TICK, 1'b0, 1'b1, 1'b0, 1'b0);
        queue_until_idle();
        wait_idle();

        apply_settings(10'd3, 8'd200, 8'd10, 8'd100, 12'd20);
        run_phase(120);
        apply_settings(10'd1, 8'd0, 8'd1, 8'd0, 12'd1);
        run_phase(100);
        apply_settings(10'd0, 8'd128, 8'd7, 8'd60, 12'd5);
        run_phase(100);
        apply_settings(10'd5, 8'd255, 8'd1, 8'd200, 12'd40);
        run_phase(120);
        // widest settings: only sequences that end on the command itself
        apply_settings(10'd1023, 8'd255, 8'd255, 8'd255, 12'd4095);
        queue_req(lmts_pkg::REQ_TURN, 1'b0, 1'b0, 1'b1, 1'b0);
        queue_req(lmts_pkg::REQ_TICK, 1'b1, 1'b1, 1'b1, 1'b1);
        queue_req(lmts_pkg::REQ_TURN, 1'b1, 1'b1, 1'b0, 1'b1);
        queue_req(REQ_UNUSED, 1'b0, 1'b0, 1'b0, 1'b0);
        wait_idle();
        apply_settings(10'd2, 8'd150, 8'd30, 8'd80, 12'd10);
        run_phase(120);

        wait_idle();
        repeat (10) @(negedge clk);
        if (expected_status.size() != 0)
        begin
            $error("%0d status words never arrived", expected_status.size());
            errors_seen++;
        end
        if (errors_seen == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

@@ lock_motor_turn_sequencer_top.f @@
hdl/lmts_pkg.sv
hdl/lmts_cfg.sv
hdl/lmts_core.sv
hdl/lock_motor_turn_sequencer_top.sv
verif/testbench.sv
